/* rtl/core/spq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  // Default number of slots in the store
  localparam int DEF_QUEUE_SLOTS = 16;

  typedef logic [1:0] status_t;

  // Result status codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  // Request opcodes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Reported on a remove from an empty queue
  localparam logic signed [31:0] EMPTY_VALUE = 32'sh8000_0000;

endpackage

`default_nettype wire

/* rtl/core/sorted_priority_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

// Remove: the tail entry is read while idle, and the result is strobed from S_REM.
// Insert: the free-slot scan and the sorted walk run in S_WORK, then S_LINK1 and S_LINK2
//   write the entry and its links; scan and walk share the cycles, one slot each per cycle.
// Full insert and empty remove answer straight from idle. One request at a time; busy covers it.
// After reset the used flags are cleared one slot per cycle, with busy high until all are clear.
// Results are strobed on done for one cycle; the receiver cannot stall them.
module sorted_priority_queue #(
  parameter int QUEUE_SLOTS = spq_pkg::DEF_QUEUE_SLOTS
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    start,
  output logic                   busy,
  input  wire                    op,
  input  wire signed [31:0]      value,
  output logic                   done,
  output spq_pkg::status_t       status,
  output logic signed [31:0]     removed_value
);
  import spq_pkg::*;

  localparam int SW = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int IW = $clog2(QUEUE_SLOTS + 1);
  localparam logic [IW-1:0] NULL_IDX = IW'(QUEUE_SLOTS);

  // Sequencer states
  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WORK  = 3'd2;
  localparam logic [2:0] S_LINK1 = 3'd3;
  localparam logic [2:0] S_LINK2 = 3'd4;
  localparam logic [2:0] S_REM   = 3'd5;

  logic [2:0]         state;
  logic [IW-1:0]      head_index;
  logic [IW-1:0]      tail_index;
  logic [IW-1:0]      count;
  logic [IW-1:0]      clr_cnt;
  logic signed [31:0] ins_value;

  // Free-slot scan
  logic [IW-1:0]      scan_addr;
  logic               scan_chk;
  logic               scan_done;
  logic [SW-1:0]      free_slot;

  // Sorted walk: new entry goes between prior and after
  logic [IW-1:0]      prior;
  logic [IW-1:0]      after;
  logic               walk_done;
  logic               walk_adv;

  // Slot store
  logic [31:0]        value_mem [QUEUE_SLOTS];
  logic [IW-1:0]      next_mem  [QUEUE_SLOTS];
  logic [IW-1:0]      prev_mem  [QUEUE_SLOTS];
  logic               used_mem  [QUEUE_SLOTS];

  logic [31:0]        val_q;
  logic [IW-1:0]      next_q;
  logic [IW-1:0]      prev_q;
  logic               used_q;

  logic [IW-1:0]      rd_addr;
  logic [IW-1:0]      new_slot;

  logic               val_we;
  logic               nxt_we;
  logic [IW-1:0]      nxt_wa;
  logic [IW-1:0]      nxt_wd;
  logic               prv_we;
  logic [IW-1:0]      prv_wa;
  logic [IW-1:0]      prv_wd;
  logic               use_we;
  logic [IW-1:0]      use_wa;
  logic               use_wd;

  assign busy     = (state != S_IDLE);
  assign new_slot = IW'(free_slot);

  // One walk step: current entry exists and is smaller than the new value
  assign walk_adv = (state == S_WORK) && !walk_done && (after != NULL_IDX) &&
                    ($signed(val_q) < ins_value);

  // Shared read address for value and next links
  always_comb begin
    case (state)
      S_IDLE:  rd_addr = (op == OP_REMOVE) ? tail_index : head_index;
      S_WORK:  rd_addr = walk_adv ? next_q : after;
      default: rd_addr = after;
    endcase
  end

  // Memory write selection
  always_comb begin
    val_we = 1'b0;
    nxt_we = 1'b0;
    nxt_wa = new_slot;
    nxt_wd = after;
    prv_we = 1'b0;
    prv_wa = new_slot;
    prv_wd = prior;
    use_we = 1'b0;
    use_wa = new_slot;
    use_wd = 1'b0;
    case (state)
      S_CLR: begin
        use_we = 1'b1;
        use_wa = clr_cnt;
      end
      S_LINK1: begin
        val_we = 1'b1;
        nxt_we = 1'b1;
        prv_we = 1'b1;
        use_we = 1'b1;
        use_wd = 1'b1;
      end
      S_LINK2: begin
        nxt_we = (prior != NULL_IDX);
        nxt_wa = prior;
        nxt_wd = new_slot;
        prv_we = (after != NULL_IDX);
        prv_wa = after;
        prv_wd = new_slot;
      end
      S_REM: begin
        use_we = 1'b1;
        use_wa = tail_index;
        nxt_we = (prev_q != NULL_IDX);
        nxt_wa = prev_q;
        nxt_wd = NULL_IDX;
      end
      default: ;
    endcase
  end

  // Slot store, registered reads
  always_ff @(posedge clk) begin
    if (val_we) value_mem[new_slot[SW-1:0]] <= ins_value;
    val_q <= value_mem[rd_addr[SW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (nxt_we) next_mem[nxt_wa[SW-1:0]] <= nxt_wd;
    next_q <= next_mem[rd_addr[SW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (prv_we) prev_mem[prv_wa[SW-1:0]] <= prv_wd;
    prev_q <= prev_mem[tail_index[SW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (use_we) used_mem[use_wa[SW-1:0]] <= use_wd;
    used_q <= used_mem[scan_addr[SW-1:0]];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr_cnt    <= '0;
      head_index <= NULL_IDX;
      tail_index <= NULL_IDX;
      count      <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == NULL_IDX - 1'b1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            ins_value <= value;
            if (op == OP_REMOVE) begin
              if (tail_index == NULL_IDX) begin
                done          <= 1'b1;
                status        <= ST_EMPTY;
                removed_value <= EMPTY_VALUE;
              end else begin
                state <= S_REM;
              end
            end else if (count == NULL_IDX) begin
              done          <= 1'b1;
              status        <= ST_FULL;
              removed_value <= '0;
            end else begin
              state     <= S_WORK;
              scan_addr <= '0;
              scan_chk  <= 1'b0;
              scan_done <= 1'b0;
              prior     <= NULL_IDX;
              after     <= head_index;
              walk_done <= 1'b0;
            end
          end
        end
        S_WORK: begin
          // free-slot scan, one flag per cycle
          if (!scan_done) begin
            if (scan_chk && !used_q) begin
              scan_done <= 1'b1;
              free_slot <= SW'(scan_addr - 1'b1);
            end else begin
              scan_addr <= scan_addr + 1'b1;
              scan_chk  <= 1'b1;
            end
          end
          // sorted walk, one entry per cycle
          if (!walk_done) begin
            if (walk_adv) begin
              prior <= after;
              after <= next_q;
            end else begin
              walk_done <= 1'b1;
            end
          end
          if (scan_done && walk_done) state <= S_LINK1;
        end
        S_LINK1: state <= S_LINK2;
        S_LINK2: begin
          if (prior == NULL_IDX) head_index <= new_slot;
          if (after == NULL_IDX) tail_index <= new_slot;
          count         <= count + 1'b1;
          done          <= 1'b1;
          status        <= ST_OK;
          removed_value <= '0;
          state         <= S_IDLE;
        end
        S_REM: begin
          if (prev_q == NULL_IDX) begin
            head_index <= NULL_IDX;
            tail_index <= NULL_IDX;
          end else begin
            tail_index <= prev_q;
          end
          count         <= count - 1'b1;
          done          <= 1'b1;
          status        <= ST_OK;
          removed_value <= $signed(val_q);
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE))
    else $error("result strobe outside idle");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= NULL_IDX)
    else $error("occupancy above slot count");

  a_ends_agree: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ((head_index == NULL_IDX) == (tail_index == NULL_IDX)))
    else $error("head and tail disagree on empty");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ((count == '0) == (head_index == NULL_IDX)))
    else $error("occupancy disagrees with list");

  a_full_report: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (count == NULL_IDX))
    else $error("full reported with free slot");

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import spq_pkg::*;

  localparam int SLOTS = DEF_QUEUE_SLOTS;
  localparam int NIL   = SLOTS;

  // One expected answer from the queue
  typedef struct packed {
    status_t     status;
    logic [31:0] value;
  } answer_t;

  logic               clk;
  logic               rst   = 1'b1;
  logic               start = 1'b0;
  logic               op    = OP_INSERT;
  logic signed [31:0] value = '0;
  logic               busy;
  logic               done;
  status_t            status;
  logic signed [31:0] removed_value;

  // Mirror of the slot store, links and ends of the list
  logic signed [31:0] q_val  [SLOTS];
  logic               q_used [SLOTS];
  int                 q_next [SLOTS];
  int                 q_prev [SLOTS];
  int                 q_head;
  int                 q_tail;

  answer_t pending_answers[$];
  answer_t want;
  int      err_count = 0;

  sorted_priority_queue #(.QUEUE_SLOTS(SLOTS)) u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .op            (op),
    .value         (value),
    .done          (done),
    .status        (status),
    .removed_value (removed_value)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp);
    err_count++;
    $display("MISMATCH at %0t: %s got %h expected %h", $realtime, what, got, exp);
  endtask

  // Applies one request to the mirror and returns the answer it produces
  function automatic answer_t predict_answer(input logic req_op,
                                             input logic signed [31:0] v);
    answer_t ans;
    int      free;
    int      pos;
    int      nxt;
    int      steps;
    int      t;
    int      p;
    ans = '{status: ST_OK, value: 32'd0};
    if (req_op == OP_INSERT) begin
      // lowest unoccupied slot
      free = NIL;
      for (int i = 0; i < SLOTS; i++) begin
        if (!q_used[i] && free == NIL) free = i;
      end
      if (free == NIL) begin
        ans.status = ST_FULL;
        return ans;
      end
      q_used[free] = 1'b1;
      q_val[free]  = v;
      if (q_head == NIL) begin
        q_next[free] = NIL;
        q_prev[free] = NIL;
        q_head = free;
        q_tail = free;
      end else if (!(q_val[q_head] < v)) begin
        // new value goes ahead of the head, equal ones included
        q_next[free]   = q_head;
        q_prev[free]   = NIL;
        q_prev[q_head] = free;
        q_head = free;
      end else begin
        pos = q_head;
        nxt = q_next[q_head];
        steps = 0;
        while (nxt < NIL && steps < SLOTS && q_val[nxt] < v) begin
          pos = nxt;
          nxt = q_next[nxt];
          steps++;
        end
        if (nxt >= NIL) nxt = NIL;
        q_next[pos]  = free;
        q_prev[free] = pos;
        q_next[free] = nxt;
        if (nxt == NIL) q_tail = free;
        else q_prev[nxt] = free;
      end
    end else begin
      if (q_tail == NIL) begin
        ans.status = ST_EMPTY;
        ans.value  = EMPTY_VALUE;
        return ans;
      end
      // unlink the tail
      t = q_tail;
      p = q_prev[t];
      ans.value = q_val[t];
      q_used[t] = 1'b0;
      if (p == NIL) begin
        q_head = NIL;
        q_tail = NIL;
      end else begin
        q_tail = p;
        q_next[p] = NIL;
      end
    end
    return ans;
  endfunction

  // Issue one request and wait until it is taken; start stays high afterward
  task automatic send_request(input logic req_op, input logic signed [31:0] v);
    start <= 1'b1;
    op    <= req_op;
    value <= v;
    do @(posedge clk); while (busy);
    pending_answers.push_back(predict_answer(req_op, v));
  endtask

  task automatic pause_requests(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Mostly back to back or short, now and then a long hold-off
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Narrow range for duplicates, extremes, or any 32-bit pattern
  function automatic logic signed [31:0] rand_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $signed($urandom_range(0, 8)) - 4;
    if (r == 4) begin
      case ($urandom_range(0, 5))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 32'sh0000_0000;
        3: return -32'sd1;
        4: return 32'sh8000_0001;
        default: return 32'sh7fff_fffe;
      endcase
    end
    return $urandom();
  endfunction

  // Result checker
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected result, status/value", {30'd0, status}, removed_value);
      end else begin
        want = pending_answers.pop_front();
        if (status !== want.status)
          report_mismatch("status", {30'd0, status}, {30'd0, want.status});
        if (removed_value !== want.value)
          report_mismatch("removed_value", removed_value, want.value);
      end
    end
  end

  task automatic test_empty_remove();
    send_request(OP_REMOVE, 32'sh7fff_ffff);
    pause_requests(pick_gap());
  endtask

  // Both ends of the signed range, zero, minus one and duplicates
  task automatic test_extreme_values();
    send_request(OP_INSERT, 32'sh8000_0000);
    send_request(OP_INSERT, 32'sh7fff_ffff);
    pause_requests(pick_gap());
    send_request(OP_INSERT, 32'sh0000_0000);
    send_request(OP_INSERT, -32'sd1);
    pause_requests(pick_gap());
    send_request(OP_INSERT, 32'sh8000_0000);
    send_request(OP_INSERT, 32'sh7fff_ffff);
    send_request(OP_REMOVE, 32'sh0);
    pause_requests(pick_gap());
    send_request(OP_REMOVE, -32'sd1);
    send_request(OP_REMOVE, 32'sh8000_0000);
    pause_requests(pick_gap());
  endtask

  // Fill every slot, then push one more
  task automatic test_full_queue();
    for (int i = 0; i < SLOTS - 3; i++) begin
      send_request(OP_INSERT, (i % 3 == 0) ? 32'sd5 : $signed(i * 1000 - 6000));
      pause_requests(pick_gap());
    end
    send_request(OP_INSERT, 32'sd42);
    pause_requests(pick_gap());
  endtask

  // Bursts with a random insert bias so the queue swings between empty and full
  task automatic test_random_traffic(input int count);
    int insert_pct;
    int burst_len;
    bit no_gaps;
    int sent;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(0, 2))
        0: insert_pct = 15;
        1: insert_pct = 50;
        default: insert_pct = 85;
      endcase
      no_gaps = ($urandom_range(0, 3) == 0);
      burst_len = $urandom_range(10, 50);
      for (int i = 0; i < burst_len && sent < count; i++) begin
        send_request(($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE,
                     rand_value());
        sent++;
        if (!no_gaps) pause_requests(pick_gap());
      end
    end
  endtask

  initial begin
    int waited;
    for (int i = 0; i < SLOTS; i++) begin
      q_val[i]  = '0;
      q_used[i] = 1'b0;
      q_next[i] = NIL;
      q_prev[i] = NIL;
    end
    q_head = NIL;
    q_tail = NIL;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_empty_remove();
    test_extreme_values();
    test_full_queue();
    test_random_traffic(1650);

    // drain outstanding answers, then let the block settle
    start <= 1'b0;
    waited = 0;
    while (pending_answers.size() != 0 && waited < 10000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SLOTS + 8) @(posedge clk);

    if (err_count == 0 && pending_answers.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
